>>> hdl/bpa_pkg.sv
// Shared constants, types and the page table reset image for the buddy page allocator.
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;
    localparam int NUM_PAGES = 1024;
    localparam int MAX_ORDER = 4;
    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int LNK_W = $clog2(NUM_PAGES + 1);
    localparam int LVL_W = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
    localparam int PFN_W = 20;
    localparam int CNT_W = 16;
    localparam int ORD_W = 4;
    localparam int CW = PFN_W + 1;
    localparam int BLK = 1 << MAX_ORDER;
    localparam int FULL_PAGES = (NUM_PAGES / BLK) * BLK;
    localparam logic [LNK_W-1:0] NIL = LNK_W'(NUM_PAGES);
    localparam logic [LNK_W-1:0] TOP_HEAD = (FULL_PAGES == 0) ? NIL : LNK_W'(FULL_PAGES - BLK);

    typedef struct packed {
        logic             free;
        logic [LVL_W-1:0] level;
        logic [LNK_W-1:0] nxt;
        logic [LNK_W-1:0] prv;
    } t_page;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        t_page            wdata;
    } t_mem_req;

    // Reset image: whole max-order blocks are free and chained from the top block down.
    function automatic t_page page_init(logic [IDX_W-1:0] idx);
        t_page pg;
        int    i;
        i = int'(idx);
        pg.free = 1'b0;
        pg.level = '0;
        pg.nxt = NIL;
        pg.prv = NIL;
        if ((i % BLK) == 0 && i < FULL_PAGES) begin
            pg.free = 1'b1;
            pg.level = LVL_W'(MAX_ORDER);
            if (i >= BLK) pg.nxt = LNK_W'(i - BLK);
            if (i + BLK < FULL_PAGES) pg.prv = LNK_W'(i + BLK);
        end
        return pg;
    endfunction
endpackage
`default_nettype wire

>>> hdl/bpa_page_mem.sv
// Single-port page table memory with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module bpa_page_mem (
    input  wire logic              i_clk,
    input  wire bpa_pkg::t_mem_req i_req,
    output bpa_pkg::t_page         o_rdata
);
    import bpa_pkg::*;

    t_page r_mem [NUM_PAGES];
    t_page r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end else begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> hdl/bpa_ctrl.sv
// Request sequencer: list heads, split and merge walks, unlink and push over the page table.
`timescale 1ns / 1ps
`default_nettype none
module bpa_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [bpa_pkg::PFN_W-1:0]    i_base,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [39:0]                  s_axis_tdata,
    input  wire logic                         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [23:0]                       m_axis_tdata,
    output bpa_pkg::t_mem_req                 o_mem_req,
    input  wire bpa_pkg::t_page               i_mem_rdata
);
    import bpa_pkg::*;

    typedef enum logic [21:0] {
        S_CLR  = 22'h000001, S_IDLE = 22'h000002, S_A0 = 22'h000004, S_A1 = 22'h000008,
        S_A2   = 22'h000010, S_F0   = 22'h000020, S_F1 = 22'h000040, S_FM = 22'h000080,
        S_FB   = 22'h000100, S_FN   = 22'h000200, S_U1 = 22'h000400, S_U2 = 22'h000800,
        S_U3   = 22'h001000, S_U4   = 22'h002000, S_U5 = 22'h004000, S_P0 = 22'h008000,
        S_P1   = 22'h010000, S_P2   = 22'h020000, S_P3 = 22'h040000, S_P4 = 22'h080000,
        S_DONE = 22'h100000, S_SPARE = 22'h200000
    } t_state;

    t_state r_state, r_ul_ret, r_ps_ret;
    logic [LNK_W-1:0] r_head [0:MAX_ORDER];
    logic [IDX_W-1:0] r_clr;
    logic             r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [PFN_W-1:0] r_pfn;
    logic [ORD_W-1:0] r_ord;
    logic [IDX_W-1:0] r_p, r_idx, r_b;
    logic [LVL_W-1:0] r_lvl, r_o;
    logic [IDX_W-1:0] r_ul_p;
    logic [LVL_W-1:0] r_ul_lvl, r_ul_new;
    logic             r_ul_set;
    logic [LNK_W-1:0] r_ul_n, r_ul_q;
    logic [IDX_W-1:0] r_ps_p;
    logic [LVL_W-1:0] r_ps_lvl;
    logic             r_ok;
    logic [PFN_W-1:0] r_res;
    logic             r_out_valid, r_out_ok;
    logic [PFN_W-1:0] r_out_pfn;

    // Allocate decode: order of the count and the lowest usable list.
    logic [ORD_W-1:0] a_o;
    logic [LVL_W-1:0] a_lvl;
    logic             a_found;
    always_comb begin
        a_o = ORD_W'(MAX_ORDER + 1);
        for (int k = MAX_ORDER; k >= 0; k--) begin
            if ((CW'(1) << k) >= CW'(r_cnt)) a_o = ORD_W'(k);
        end
        a_lvl = '0;
        a_found = 1'b0;
        for (int k = MAX_ORDER; k >= 0; k--) begin
            if (ORD_W'(k) >= a_o && r_head[k] != NIL) begin
                a_lvl = LVL_W'(k);
                a_found = 1'b1;
            end
        end
    end

    // Free decode: page index and the range, order and alignment checks.
    logic [PFN_W-1:0] f_idx;
    logic [CW-1:0]    f_size;
    logic             f_good;
    logic [CW-1:0]    m_b;
    logic [CW-1:0]    a_split;
    logic [LVL_W-1:0] a_nl;
    always_comb begin
        f_idx = r_pfn - i_base;
        f_size = CW'(1) << r_ord;
        f_good = (r_ord <= ORD_W'(MAX_ORDER))
              && (CW'(f_idx) + f_size <= CW'(NUM_PAGES))
              && ((CW'(f_idx) & (f_size - CW'(1))) == '0);
        m_b = CW'(r_idx) ^ (CW'(1) << r_lvl);
        a_nl = r_lvl - LVL_W'(1);
        a_split = CW'(r_p) + (CW'(1) << a_nl);
    end

    logic [LNK_W-1:0] ps_h;
    assign ps_h = r_head[r_ps_lvl];

    // Memory port: one read or one write per cycle, chosen by the state.
    always_comb begin
        o_mem_req.we = 1'b0;
        o_mem_req.addr = '0;
        o_mem_req.wdata = i_mem_rdata;
        case (r_state)
            S_CLR: begin
                o_mem_req.we = 1'b1;
                o_mem_req.addr = r_clr;
                o_mem_req.wdata = page_init(r_clr);
            end
            S_A0: o_mem_req.addr = r_head[a_lvl][IDX_W-1:0];
            S_F0: o_mem_req.addr = f_idx[IDX_W-1:0];
            S_FM: o_mem_req.addr = m_b[IDX_W-1:0];
            S_U1: o_mem_req.addr = r_ul_q[IDX_W-1:0];
            S_U2: begin
                o_mem_req.we = 1'b1;
                o_mem_req.addr = r_ul_q[IDX_W-1:0];
                o_mem_req.wdata.nxt = r_ul_n;
            end
            S_U3: o_mem_req.addr = r_ul_n[IDX_W-1:0];
            S_U4: begin
                o_mem_req.we = 1'b1;
                o_mem_req.addr = r_ul_n[IDX_W-1:0];
                o_mem_req.wdata.prv = r_ul_q;
            end
            S_U5: begin
                o_mem_req.we = 1'b1;
                o_mem_req.addr = r_ul_p;
                o_mem_req.wdata.free = 1'b0;
                o_mem_req.wdata.level = r_ul_set ? r_ul_new : r_ul_lvl;
                o_mem_req.wdata.nxt = NIL;
                o_mem_req.wdata.prv = NIL;
            end
            S_P0: o_mem_req.addr = r_ps_p;
            S_P2: o_mem_req.addr = ps_h[IDX_W-1:0];
            S_P3: begin
                o_mem_req.we = 1'b1;
                o_mem_req.addr = ps_h[IDX_W-1:0];
                o_mem_req.wdata.prv = LNK_W'(r_ps_p);
            end
            S_P4: begin
                o_mem_req.we = 1'b1;
                o_mem_req.addr = r_ps_p;
                o_mem_req.wdata.free = 1'b1;
                o_mem_req.wdata.level = r_ps_lvl;
                o_mem_req.wdata.nxt = ps_h;
                o_mem_req.wdata.prv = NIL;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= MAX_ORDER; k++) begin
                r_head[k] <= (k == MAX_ORDER) ? TOP_HEAD : NIL;
            end
        end else begin
            if (r_state == S_DONE && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == IDX_W'(NUM_PAGES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op <= s_axis_tuser;
                        r_cnt <= s_axis_tdata[15:0];
                        r_pfn <= s_axis_tdata[35:16];
                        r_ord <= s_axis_tdata[39:36];
                        r_ok <= 1'b0;
                        r_res <= '0;
                        r_state <= s_axis_tuser ? S_F0 : S_A0;
                    end
                end
                S_A0: begin
                    if (r_cnt == '0 || a_o > ORD_W'(MAX_ORDER) || !a_found) begin
                        r_state <= S_DONE;
                    end else begin
                        r_p <= r_head[a_lvl][IDX_W-1:0];
                        r_lvl <= a_lvl;
                        r_o <= a_o[LVL_W-1:0];
                        r_state <= S_A1;
                    end
                end
                S_A1: begin
                    r_ul_p <= r_p;
                    r_ul_lvl <= i_mem_rdata.level;
                    r_ul_n <= i_mem_rdata.nxt;
                    r_ul_q <= i_mem_rdata.prv;
                    r_ul_set <= 1'b1;
                    r_ul_new <= r_o;
                    r_ul_ret <= S_A2;
                    r_state <= S_U1;
                end
                S_A2: begin
                    if (r_lvl > r_o) begin
                        r_lvl <= a_nl;
                        if (a_split < CW'(NUM_PAGES)) begin
                            r_ps_p <= a_split[IDX_W-1:0];
                            r_ps_lvl <= a_nl;
                            r_ps_ret <= S_A2;
                            r_state <= S_P0;
                        end
                    end else begin
                        r_ok <= 1'b1;
                        r_res <= i_base + PFN_W'(r_p);
                        r_state <= S_DONE;
                    end
                end
                S_F0: begin
                    r_idx <= f_idx[IDX_W-1:0];
                    r_lvl <= r_ord[LVL_W-1:0];
                    r_state <= f_good ? S_F1 : S_DONE;
                end
                S_F1: begin
                    r_state <= i_mem_rdata.free ? S_DONE : S_FM;
                end
                S_FM: begin
                    r_b <= m_b[IDX_W-1:0];
                    if (r_lvl < LVL_W'(MAX_ORDER) && m_b < CW'(NUM_PAGES)) begin
                        r_state <= S_FB;
                    end else begin
                        r_ps_p <= r_idx;
                        r_ps_lvl <= r_lvl;
                        r_ps_ret <= S_DONE;
                        r_ok <= 1'b1;
                        r_state <= S_P0;
                    end
                end
                S_FB: begin
                    if (i_mem_rdata.free && i_mem_rdata.level == r_lvl) begin
                        r_ul_p <= r_b;
                        r_ul_lvl <= i_mem_rdata.level;
                        r_ul_n <= i_mem_rdata.nxt;
                        r_ul_q <= i_mem_rdata.prv;
                        r_ul_set <= 1'b0;
                        r_ul_ret <= S_FN;
                        r_state <= S_U1;
                    end else begin
                        r_ps_p <= r_idx;
                        r_ps_lvl <= r_lvl;
                        r_ps_ret <= S_DONE;
                        r_ok <= 1'b1;
                        r_state <= S_P0;
                    end
                end
                S_FN: begin
                    r_idx <= r_idx & r_b;
                    r_lvl <= r_lvl + LVL_W'(1);
                    r_state <= S_FM;
                end
                S_U1: begin
                    if (r_ul_q != NIL) begin
                        r_state <= S_U2;
                    end else begin
                        if (r_head[r_ul_lvl] == LNK_W'(r_ul_p)) r_head[r_ul_lvl] <= r_ul_n;
                        r_state <= S_U3;
                    end
                end
                S_U2: r_state <= S_U3;
                S_U3: r_state <= (r_ul_n != NIL) ? S_U4 : S_U5;
                S_U4: r_state <= S_U5;
                S_U5: r_state <= r_ul_ret;
                S_P0: r_state <= S_P1;
                S_P1: begin
                    // A page that is already a free head leaves its old list first.
                    if (i_mem_rdata.free) begin
                        r_ul_p <= r_ps_p;
                        r_ul_lvl <= i_mem_rdata.level;
                        r_ul_n <= i_mem_rdata.nxt;
                        r_ul_q <= i_mem_rdata.prv;
                        r_ul_set <= 1'b0;
                        r_ul_ret <= S_P2;
                        r_state <= S_U1;
                    end else begin
                        r_state <= S_P2;
                    end
                end
                S_P2: r_state <= (ps_h != NIL) ? S_P3 : S_P4;
                S_P3: r_state <= S_P4;
                S_P4: begin
                    r_head[r_ps_lvl] <= LNK_W'(r_ps_p);
                    r_state <= r_ps_ret;
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_ok <= r_ok;
                        r_out_pfn <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = {3'b000, r_out_pfn, r_out_ok};
endmodule
`default_nettype wire

>>> hdl/buddy_page_allocator_top.sv
// Top level of the buddy page allocator: configuration register, sequencer and page table.
`timescale 1ns / 1ps
`default_nettype none
// Binary buddy allocator over NUM_PAGES pages in blocks of up to 2^MAX_ORDER pages. Each
// input item is an allocate or a free and gives exactly one result item. After reset the
// block writes every page table entry before it takes its first item. One item at a time
// is worked on, and how long an allocate or a free takes is set by the single-port page
// table: every unlink or push is a chain of reads and writes of neighboring list entries,
// once per split or merge level. A result waits in an output register while the next
// item is already taken.
module buddy_page_allocator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [19:0] i_cfg_data,     // base_page
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // page_count[15:0], page_number[35:16], free_order[39:36]
    input  wire logic        s_axis_tuser,   // op: 0 allocate, 1 free
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // ok[0], page_number_out[20:1], zero fill
);
    import bpa_pkg::*;

    logic [PFN_W-1:0] r_base;
    t_mem_req         mem_req;
    t_page            mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_valid) begin
            r_base <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_base        (r_base),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_mem_req     (mem_req),
        .i_mem_rdata   (mem_rdata)
    );

    bpa_page_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );
endmodule
`default_nettype wire
